// ----- hw/rtl/mspwm_pkg.sv -----
package mspwm_pkg;

	localparam int CHANNELS = 8;
	localparam int CH_W     = 3;
	localparam int PERIOD_W = 16;
	localparam int DUTY_W   = 8;
	localparam int PCT_W    = 7;
	localparam int PROD_W   = PERIOD_W + PCT_W;
	localparam int LEN_W    = 16;

	localparam logic [PCT_W-1:0]  PCT_FULL  = 7'd100;
	localparam logic [DUTY_W-1:0] DUTY_FULL = 8'd100;

	// x/100 == (x>>2)/25; (x>>2) < 2^21, so m = ceil(2^26/25) is exact
	localparam int              DIV_SHIFT = 26;
	localparam int              DIV_MUL_W = 22;
	localparam logic [21:0]     DIV_MUL   = 22'd2684355;
	localparam int              DIV_IN_W  = PROD_W - 2;
	localparam int              DIV_P_W   = DIV_IN_W + DIV_MUL_W;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_STOP  = 2'd2;

	localparam logic [1:0] KIND_OFF = 2'd0;
	localparam logic [1:0] KIND_ON  = 2'd1;
	localparam logic [1:0] KIND_RUN = 2'd2;

	typedef struct packed {
		logic [1:0]       kind;
		logic [LEN_W-1:0] hi;
		logic [LEN_W-1:0] lo;
	} len_t;

endpackage

// ----- hw/rtl/mspwm_len.sv -----
module mspwm_len import mspwm_pkg::*; (
	input  logic                clk,
	input  logic                en_s2,
	input  logic                en_s3,
	input  logic [PERIOD_W-1:0] period_s1,
	input  logic [DUTY_W-1:0]   duty_s1,
	output len_t                len_s3
);

	logic [PCT_W-1:0]   dsat;
	logic [1:0]         kind;
	logic [PROD_W-1:0]  prod_hi_s2;
	logic [PROD_W-1:0]  prod_lo_s2;
	logic [1:0]         kind_s2;
	logic [DIV_P_W-1:0] mul_hi;
	logic [DIV_P_W-1:0] mul_lo;
	logic [LEN_W-1:0]   q_hi;
	logic [LEN_W-1:0]   q_lo;

	always_comb begin
		dsat = (duty_s1 > DUTY_FULL) ? PCT_FULL : duty_s1[PCT_W-1:0];
		if (dsat == '0) begin
			kind = KIND_OFF;
		end else if (dsat == PCT_FULL) begin
			kind = KIND_ON;
		end else begin
			kind = KIND_RUN;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			prod_hi_s2 <= PROD_W'(period_s1) * PROD_W'(dsat);
			prod_lo_s2 <= PROD_W'(period_s1) * PROD_W'(PCT_FULL - dsat);
			kind_s2    <= kind;
		end
	end

	assign mul_hi = DIV_P_W'(prod_hi_s2[PROD_W-1:2]) * DIV_P_W'(DIV_MUL);
	assign mul_lo = DIV_P_W'(prod_lo_s2[PROD_W-1:2]) * DIV_P_W'(DIV_MUL);
	assign q_hi   = mul_hi[DIV_SHIFT+LEN_W-1:DIV_SHIFT];
	assign q_lo   = mul_lo[DIV_SHIFT+LEN_W-1:DIV_SHIFT];

	always_ff @(posedge clk) begin
		if (en_s3) begin
			len_s3.kind <= kind_s2;
			len_s3.hi   <= (q_hi == '0) ? LEN_W'(1) : q_hi;
			len_s3.lo   <= (q_lo == '0) ? LEN_W'(1) : q_lo;
		end
	end

endmodule

// ----- hw/rtl/mspwm_chan.sv -----
module mspwm_chan import mspwm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                upd,
	input  logic [1:0]          cmd,
	input  logic [CH_W-1:0]     ch,
	input  len_t                len,
	output logic [CHANNELS-1:0] level_nx,
	output logic [CHANNELS-1:0] active_nx
);

	logic [CHANNELS-1:0] level_q;
	logic [CHANNELS-1:0] active_q;
	logic [LEN_W-1:0]    hi_q  [CHANNELS];
	logic [LEN_W-1:0]    lo_q  [CHANNELS];
	logic [LEN_W-1:0]    rem_q [CHANNELS];
	logic [LEN_W-1:0]    hi_nx [CHANNELS];
	logic [LEN_W-1:0]    lo_nx [CHANNELS];
	logic [LEN_W-1:0]    rem_nx[CHANNELS];

	always_comb begin
		level_nx  = level_q;
		active_nx = active_q;
		for (int i = 0; i < CHANNELS; i++) begin
			hi_nx[i]  = hi_q[i];
			lo_nx[i]  = lo_q[i];
			rem_nx[i] = rem_q[i];
			case (cmd)
				CMD_TICK: begin
					if (active_q[i]) begin
						if (rem_q[i] <= LEN_W'(1)) begin
							level_nx[i] = ~level_q[i];
							rem_nx[i]   = level_q[i] ? lo_q[i] : hi_q[i];
						end else begin
							rem_nx[i] = rem_q[i] - LEN_W'(1);
						end
					end
				end
				CMD_START: begin
					if (ch == CH_W'(i)) begin
						active_nx[i] = 1'b0;
						rem_nx[i]    = '0;
						case (len.kind)
							KIND_OFF: level_nx[i] = 1'b0;
							KIND_ON:  level_nx[i] = 1'b1;
							KIND_RUN: begin
								hi_nx[i]     = len.hi;
								lo_nx[i]     = len.lo;
								rem_nx[i]    = len.hi;
								level_nx[i]  = 1'b1;
								active_nx[i] = 1'b1;
							end
							default: ;
						endcase
					end
				end
				CMD_STOP: begin
					if (ch == CH_W'(i)) begin
						active_nx[i] = 1'b0;
						level_nx[i]  = 1'b0;
						rem_nx[i]    = '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= '0;
			active_q <= '0;
		end else if (upd) begin
			level_q  <= level_nx;
			active_q <= active_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			for (int i = 0; i < CHANNELS; i++) begin
				hi_q[i]  <= hi_nx[i];
				lo_q[i]  <= lo_nx[i];
				rem_q[i] <= rem_nx[i];
			end
		end
	end

endmodule

// ----- hw/rtl/multichannel_ms_pwm_generator_unit.sv -----
// Eight PWM channels stepped by one-millisecond tick beats. Each input beat (tick,
// start or stop) yields exactly one output beat with all pin levels and the running
// mask after that command. One beat is taken per clock unless back-pressure stalls the pipeline;
// an output beat passes the input register and the two multiplier stages that
// turn period and percent duty into high and low phase lengths (product, then divide
// by 100 through a reciprocal multiply) ahead of the channel state update.
module multichannel_ms_pwm_generator_unit import mspwm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // channel[2:0], period[18:3], duty[26:19], zero fill
	input  logic [1:0]  s_tuser,  // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // pin_levels[7:0], running_mask[15:8]
);

	logic                valid_s1, valid_s2, valid_s3;
	logic [1:0]          cmd_s1, cmd_s2, cmd_s3;
	logic [CH_W-1:0]     ch_s1, ch_s2, ch_s3;
	logic [PERIOD_W-1:0] period_s1;
	logic [DUTY_W-1:0]   duty_s1;
	logic                rdy_s1, rdy_s2, rdy_s3, adv_out, upd;
	len_t                len_s3;
	logic [CHANNELS-1:0] level_nx, active_nx;
	logic                out_valid_q;
	logic [15:0]         out_data_q;

	assign adv_out  = !out_valid_q || m_tready;
	assign rdy_s3   = !valid_s3 || adv_out;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign upd      = valid_s3 && adv_out;
	assign s_tready = rdy_s1;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= s_tvalid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
			if (adv_out) out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			cmd_s1    <= s_tuser;
			ch_s1     <= s_tdata[2:0];
			period_s1 <= s_tdata[18:3];
			duty_s1   <= s_tdata[26:19];
		end
		if (rdy_s2) begin
			cmd_s2 <= cmd_s1;
			ch_s2  <= ch_s1;
		end
		if (rdy_s3) begin
			cmd_s3 <= cmd_s2;
			ch_s3  <= ch_s2;
		end
		if (upd) begin
			out_data_q <= {active_nx, level_nx};
		end
	end

	mspwm_len u_len (
		.clk       (clk),
		.en_s2     (rdy_s2),
		.en_s3     (rdy_s3),
		.period_s1 (period_s1),
		.duty_s1   (duty_s1),
		.len_s3    (len_s3)
	);

	mspwm_chan u_chan (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (upd),
		.cmd       (cmd_s3),
		.ch        (ch_s3),
		.len       (len_s3),
		.level_nx  (level_nx),
		.active_nx (active_nx)
	);

endmodule

// ----- hw/rtl/mspwm_chk.sv -----
module mspwm_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	logic [2:0] cnt_q;
	logic       acc_in, acc_out;

	assign acc_in  = s_tvalid && s_tready;
	assign acc_out = m_tvalid && m_tready;

	// beats in flight between the two sides
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 3'(acc_in) - 3'(acc_out);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat dropped or changed while stalled");

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("more beats in flight than pipeline stages");

	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 3'd0 |-> !m_tvalid)
		else $error("output beat without input beat");

endmodule

bind multichannel_ms_pwm_generator_unit mspwm_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
